FILE: hw/rtl/pgm_pkg.sv
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared widths, register indexes and size limits of the Prewitt gradient
// magnitude block.
// ----------------------------------------------------------------------------
package pgm_pkg;

   // field widths
   localparam int PIXEL_W      = 8;
   localparam int MAG_W        = 8;
   localparam int ROW_W        = 12;
   localparam int COL_W        = 10;

   // configuration registers
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

   // frame size limits
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int MIN_DIM       = 3;

endpackage

FILE: hw/rtl/pgm_req_if.sv
// ----------------------------------------------------------------------------
// pgm_req_if
// Pixel input channel: valid/ready handshake with pixel and frame start.
// ----------------------------------------------------------------------------
interface pgm_req_if;
   import pgm_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);

endinterface

FILE: hw/rtl/pgm_rsp_if.sv
// ----------------------------------------------------------------------------
// pgm_rsp_if
// Result channel: valid/ready handshake with magnitude and centre position.
// ----------------------------------------------------------------------------
interface pgm_rsp_if;
   import pgm_pkg::*;

   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic [ROW_W-1:0] centre_row;
   logic [COL_W-1:0] centre_col;
   logic             frame_done;

   modport source (output valid, output magnitude, output centre_row,
                   output centre_col, output frame_done, input ready);
   modport sink   (input valid, input magnitude, input centre_row,
                   input centre_col, input frame_done, output ready);

endinterface

FILE: hw/rtl/prewitt_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// prewitt_gradient_magnitude
// 3x3 Prewitt edge magnitude over a raster-order gray pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns, for each interior pixel, the floor of
// sqrt(gx^2 + gy^2) saturated at 255, with its row and column; border pixels
// give no result. The whole pipeline moves as one: when a result sits
// unaccepted on the output, no new pixel is taken. The two previous rows live
// in one line RAM (one read and one write a cycle, both rows side by side in
// each word), which sets the one-pixel-per-clock figure; a back-to-back pixel
// at the column just written is served by forwarding. The square root runs as
// a four-stage pipeline, two result bits per stage. The line RAM needs no
// clearing after reset.
module prewitt_gradient_magnitude #(
   parameter int MAX_WIDTH = pgm_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   pgm_req_if.sink                           req_if,
   pgm_rsp_if.source                         rsp_if,
   input  logic                              csr_write_en,
   input  logic [pgm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pgm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pgm_pkg::*;

   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int DIM_W       = 13;
   localparam int LINE_W      = 2 * PIXEL_W;
   localparam int SUM_W       = PIXEL_W + 2;
   localparam int GRAD_W      = SUM_W + 1;
   localparam int SQ_W        = 2 * GRAD_W - 2;
   localparam int ROOT_IN_W   = 2 * MAG_W;
   localparam int ROOT_BITS   = 2;
   localparam int ROOT_STAGES = MAG_W / ROOT_BITS;

   typedef struct packed {
      logic [MAG_W-1:0]     res;
      logic [ROOT_IN_W-1:0] sq;
   } root_type;

   // one restoring square-root step at result bit k, keeping res squared
   function automatic root_type root_step(input logic [ROOT_IN_W-1:0] val,
                                          input root_type cur, input int k);
      root_type           nxt;
      logic [ROOT_IN_W:0] trial;
      nxt   = cur;
      trial = (ROOT_IN_W+1)'(cur.sq) + ((ROOT_IN_W+1)'(cur.res) << (k + 1))
            + ((ROOT_IN_W+1)'(1) << (2 * k));
      if (trial <= {1'b0, val}) begin
         nxt.res[k] = 1'b1;
         nxt.sq     = trial[ROOT_IN_W-1:0];
      end
      return nxt;
   endfunction

   // ------------------------------------------------------------------------
   // declarations
   // ------------------------------------------------------------------------
   logic                    advance;
   logic                    accept;

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0]        width_eff, height_eff;

   logic [COL_W-1:0]        col_ff, col_in, cur_col;
   logic [ROW_W-1:0]        row_ff, row_in, cur_row;
   logic [DIM_W-1:0]        col_inc, row_inc;
   logic                    line_end;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    emit_in, done_in, fwd_in;

   logic                    b_valid_ff;
   logic                    b_emit_ff, b_done_ff, b_fwd_ff;
   logic [PIXEL_W-1:0]      b_pixel_ff;
   logic [ROW_W-1:0]        b_row_ff;
   logic [COL_W-1:0]        b_col_ff;
   logic [ADDR_W-1:0]       b_addr_ff;
   logic [LINE_W-1:0]       b_fwd_data_ff;
   logic [LINE_W-1:0]       ram_rd_data, line_word;
   logic [PIXEL_W-1:0]      b_top, b_mid;
   logic [PIXEL_W-1:0]      win_ff [6];
   logic [PIXEL_W-1:0]      win_in [6];
   logic [SUM_W-1:0]        right_sum, left_sum, bottom_sum, upper_sum;
   logic signed [GRAD_W-1:0] gx_in, gy_in;

   logic                    c_valid_ff, c_done_ff;
   logic signed [GRAD_W-1:0] c_gx_ff, c_gy_ff;
   logic [ROW_W-1:0]        c_row_ff;
   logic [COL_W-1:0]        c_col_ff;
   logic signed [2*GRAD_W-1:0] prod_x, prod_y;

   logic                    d_valid_ff, d_done_ff;
   logic [SQ_W-1:0]         d_sqx_ff, d_sqy_ff;
   logic [ROW_W-1:0]        d_row_ff;
   logic [COL_W-1:0]        d_col_ff;
   logic [SQ_W:0]           sum_in;

   logic                    rt_valid_ff [ROOT_STAGES+1];
   logic                    rt_sat_ff   [ROOT_STAGES+1];
   logic                    rt_done_ff  [ROOT_STAGES+1];
   logic [ROOT_IN_W-1:0]    rt_val_ff   [ROOT_STAGES+1];
   root_type                rt_root_ff  [ROOT_STAGES+1];
   logic [ROW_W-1:0]        rt_row_ff   [ROOT_STAGES+1];
   logic [COL_W-1:0]        rt_col_ff   [ROOT_STAGES+1];
   root_type                rt_root_in  [ROOT_STAGES];

   logic                    out_valid_ff, out_done_ff;
   logic [MAG_W-1:0]        out_mag_ff;
   logic [ROW_W-1:0]        out_row_ff;
   logic [COL_W-1:0]        out_col_ff;

   // ------------------------------------------------------------------------
   // handshake: the pipeline moves whenever the output stage can take a value
   // ------------------------------------------------------------------------
   assign advance      = !out_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && advance;
   assign req_if.ready = advance;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // effective frame size, clamped to the supported range
   always_comb begin
      width_eff = DIM_W'(width_ff);
      if (DIM_W'(width_ff) < DIM_W'(MIN_DIM)) begin
         width_eff = DIM_W'(MIN_DIM);
      end else if (DIM_W'(width_ff) > DIM_W'(MAX_WIDTH)) begin
         width_eff = DIM_W'(MAX_WIDTH);
      end
      height_eff = DIM_W'(height_ff);
      if (DIM_W'(height_ff) < DIM_W'(MIN_DIM)) begin
         height_eff = DIM_W'(MIN_DIM);
      end else if (DIM_W'(height_ff) > DIM_W'(MAX_HEIGHT)) begin
         height_eff = DIM_W'(MAX_HEIGHT);
      end
   end

   // ------------------------------------------------------------------------
   // position counters and line RAM read address
   // ------------------------------------------------------------------------
   always_comb begin
      cur_col  = req_if.frame_start ? '0 : col_ff;
      cur_row  = req_if.frame_start ? '0 : row_ff;
      col_inc  = DIM_W'(cur_col) + DIM_W'(1);
      row_inc  = DIM_W'(cur_row) + DIM_W'(1);
      line_end = col_inc >= width_eff;
      rd_addr  = ADDR_W'(cur_col);
      emit_in  = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
      done_in  = (row_inc == height_eff) && (col_inc == width_eff);
      // the item now in stage b writes this column at the same edge
      fwd_in   = b_valid_ff && (b_addr_ff == rd_addr);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (line_end) begin
            col_in = '0;
            row_in = (row_inc >= height_eff) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
            row_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // line RAM: upper byte two rows up, lower byte one row up
   // ------------------------------------------------------------------------
   pgm_ram #(
      .DATA_W (LINE_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance && b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data ({b_mid, b_pixel_ff}),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // stage b: window and gradients
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_pixel_ff    <= req_if.pixel;
         b_emit_ff     <= emit_in;
         b_done_ff     <= done_in;
         b_row_ff      <= cur_row - ROW_W'(1);
         b_col_ff      <= cur_col - COL_W'(1);
         b_addr_ff     <= rd_addr;
         b_fwd_ff      <= fwd_in;
         b_fwd_data_ff <= {b_mid, b_pixel_ff};
      end
   end

   assign line_word = b_fwd_ff ? b_fwd_data_ff : ram_rd_data;
   assign b_top     = line_word[LINE_W-1:PIXEL_W];
   assign b_mid     = line_word[PIXEL_W-1:0];

   // window shift: older column moves left, new column enters on the right
   always_comb begin
      win_in[0] = win_ff[0];
      win_in[1] = win_ff[1];
      win_in[2] = win_ff[2];
      win_in[3] = win_ff[3];
      win_in[4] = win_ff[4];
      win_in[5] = win_ff[5];
      if (advance && b_valid_ff) begin
         win_in[0] = win_ff[3];
         win_in[1] = win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = b_top;
         win_in[4] = b_mid;
         win_in[5] = b_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // column and row sums
   always_comb begin
      right_sum  = SUM_W'(b_top) + SUM_W'(b_mid) + SUM_W'(b_pixel_ff);
      left_sum   = SUM_W'(win_ff[0]) + SUM_W'(win_ff[1]) + SUM_W'(win_ff[2]);
      bottom_sum = SUM_W'(win_ff[2]) + SUM_W'(win_ff[5]) + SUM_W'(b_pixel_ff);
      upper_sum  = SUM_W'(win_ff[0]) + SUM_W'(win_ff[3]) + SUM_W'(b_top);
      gx_in      = GRAD_W'(right_sum) - GRAD_W'(left_sum);
      gy_in      = GRAD_W'(bottom_sum) - GRAD_W'(upper_sum);
   end

   // ------------------------------------------------------------------------
   // stage c: squares
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff && b_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_gx_ff   <= gx_in;
         c_gy_ff   <= gy_in;
         c_row_ff  <= b_row_ff;
         c_col_ff  <= b_col_ff;
         c_done_ff <= b_done_ff;
      end
   end

   assign prod_x = c_gx_ff * c_gx_ff;
   assign prod_y = c_gy_ff * c_gy_ff;

   // ------------------------------------------------------------------------
   // stage d: sum of squares and saturation test
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_sqx_ff  <= prod_x[SQ_W-1:0];
         d_sqy_ff  <= prod_y[SQ_W-1:0];
         d_row_ff  <= c_row_ff;
         d_col_ff  <= c_col_ff;
         d_done_ff <= c_done_ff;
      end
   end

   assign sum_in = (SQ_W+1)'(d_sqx_ff) + (SQ_W+1)'(d_sqy_ff);

   // ------------------------------------------------------------------------
   // square root pipeline, two result bits per stage
   // ------------------------------------------------------------------------
   always_comb begin
      for (int s = 0; s < ROOT_STAGES; s++) begin
         rt_root_in[s] = rt_root_ff[s];
         for (int j = 0; j < ROOT_BITS; j++) begin
            rt_root_in[s] = root_step(rt_val_ff[s], rt_root_in[s],
                                      MAG_W - 1 - s * ROOT_BITS - j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= ROOT_STAGES; s++) begin
            rt_valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         rt_valid_ff[0] <= d_valid_ff;
         for (int s = 1; s <= ROOT_STAGES; s++) begin
            rt_valid_ff[s] <= rt_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rt_val_ff[0]  <= sum_in[ROOT_IN_W-1:0];
         rt_sat_ff[0]  <= |sum_in[SQ_W:ROOT_IN_W];
         rt_root_ff[0] <= '0;
         rt_row_ff[0]  <= d_row_ff;
         rt_col_ff[0]  <= d_col_ff;
         rt_done_ff[0] <= d_done_ff;
         for (int s = 1; s <= ROOT_STAGES; s++) begin
            rt_val_ff[s]  <= rt_val_ff[s-1];
            rt_sat_ff[s]  <= rt_sat_ff[s-1];
            rt_root_ff[s] <= rt_root_in[s-1];
            rt_row_ff[s]  <= rt_row_ff[s-1];
            rt_col_ff[s]  <= rt_col_ff[s-1];
            rt_done_ff[s] <= rt_done_ff[s-1];
         end
      end
   end

   // ------------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= rt_valid_ff[ROOT_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_mag_ff  <= rt_sat_ff[ROOT_STAGES] ? '1 : rt_root_ff[ROOT_STAGES].res;
         out_row_ff  <= rt_row_ff[ROOT_STAGES];
         out_col_ff  <= rt_col_ff[ROOT_STAGES];
         out_done_ff <= rt_done_ff[ROOT_STAGES];
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.magnitude  = out_mag_ff;
   assign rsp_if.centre_row = out_row_ff;
   assign rsp_if.centre_col = out_col_ff;
   assign rsp_if.frame_done = out_done_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // a held result blocks new pixels
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("pixel taken while result stalled");

   // results only ever come from interior centres
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_row_ff != '0) && (out_col_ff != '0))
      else $error("result for a border pixel");

   // the frame done flag marks the last interior centre
   a_done_position: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_done_ff) |->
         (DIM_W'(out_row_ff) + DIM_W'(2) == height_eff) &&
         (DIM_W'(out_col_ff) + DIM_W'(2) == width_eff))
      else $error("frame done away from the last centre");

   // the column counter stays inside the line after each transaction
   a_col_in_line: assert property (@(posedge clock) disable iff (reset)
      accept |=> DIM_W'(col_ff) < width_eff)
      else $error("column counter past line end");

endmodule

FILE: hw/rtl/pgm_ram.sv
// ----------------------------------------------------------------------------
// pgm_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module pgm_ram #(
   parameter  int DATA_W = 16,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Prewitt gradient magnitude block. Pixels stream
// in with bursty valid and a stalling result sink. Each accepted pixel runs
// through a local line-buffer and window model that predicts the gradient
// result. Every result is checked field by field in order. Frame sizes cover
// the reset values, the smallest frame, values below the minimum that clamp
// and a spread of small random sizes.
// ----------------------------------------------------------------------------
module testbench;
   import pgm_pkg::*;

   localparam int SETTLE_CYCLES = 16;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_PIXELS = 320;

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic [ROW_W-1:0] centre_row;
      logic [COL_W-1:0] centre_col;
      logic             frame_done;
   } gradient_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_PERIODIC
   } sink_mode_type;

   class gradient_scoreboard;
      bit [PIXEL_W-1:0]      line_above [MAX_WIDTH_DEF];
      bit [PIXEL_W-1:0]      line_two_above [MAX_WIDTH_DEF];
      bit                    above_written [MAX_WIDTH_DEF];
      bit                    two_above_written [MAX_WIDTH_DEF];
      bit [PIXEL_W-1:0]      window [6];
      bit                    window_written [6];
      int unsigned           col_pos;
      int unsigned           row_pos;
      bit [WIDTH_REG_W-1:0]  width_reg;
      bit [HEIGHT_REG_W-1:0] height_reg;
      gradient_type          expected_gradients [$];
      int unsigned           errors;
      int unsigned           pixels_seen;
      int unsigned           gradients_checked;
      int unsigned           frames_closed;

      function new();
         foreach (line_above[i]) begin
            line_above[i]        = '0;
            line_two_above[i]    = '0;
            above_written[i]     = 1'b0;
            two_above_written[i] = 1'b0;
         end
         // window registers clear on reset, so they count as written
         foreach (window[i]) begin
            window[i]         = '0;
            window_written[i] = 1'b1;
         end
         col_pos           = 0;
         row_pos           = 0;
         width_reg         = IMAGE_WIDTH_RESET;
         height_reg        = IMAGE_HEIGHT_RESET;
         errors            = 0;
         pixels_seen       = 0;
         gradients_checked = 0;
         frames_closed     = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         if (index == CSR_IMAGE_WIDTH) width_reg = value[WIDTH_REG_W-1:0];
         else if (index == CSR_IMAGE_HEIGHT) height_reg = value[HEIGHT_REG_W-1:0];
      endfunction

      function int unsigned active_width();
         if (width_reg < MIN_DIM) return MIN_DIM;
         if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
         return width_reg;
      endfunction

      function int unsigned active_height();
         if (height_reg < MIN_DIM) return MIN_DIM;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return height_reg;
      endfunction

      // would this pixel complete a window that touches a never-written line entry
      function bit reads_unwritten(bit start);
         int unsigned r;
         int unsigned c;
         r = start ? 0 : row_pos;
         c = start ? 0 : col_pos % MAX_WIDTH_DEF;
         if (r < 2 || c < 2) return 1'b0;
         return !(two_above_written[c] && above_written[c] && window_written[0] &&
                  window_written[1] && window_written[2] && window_written[3] &&
                  window_written[5]);
      endfunction

      // floor of the square root, pinned at full scale
      function int unsigned root_floor_sat(int unsigned v);
         int unsigned root;
         int unsigned trial;
         if (v >= 65536) return 255;
         root = 0;
         for (int b = 7; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      function void note_pixel(bit [PIXEL_W-1:0] p, bit start);
         int unsigned  w;
         int unsigned  h;
         int unsigned  r;
         int unsigned  c;
         int           top;
         int           mid;
         int           gx;
         int           gy;
         bit           top_known;
         bit           mid_known;
         gradient_type g;
         w = active_width();
         h = active_height();
         pixels_seen++;
         if (start) begin
            col_pos = 0;
            row_pos = 0;
         end
         r         = row_pos;
         c         = col_pos % MAX_WIDTH_DEF;
         top       = line_two_above[c];
         mid       = line_above[c];
         top_known = two_above_written[c];
         mid_known = above_written[c];

         // interior centre: horizontal and vertical differences of the 3x3
         if (r >= 2 && col_pos >= 2) begin
            gx = (top + mid + int'(p)) -
                 (int'(window[0]) + int'(window[1]) + int'(window[2]));
            gy = (int'(window[2]) + int'(window[5]) + int'(p)) -
                 (int'(window[0]) + int'(window[3]) + top);
            g.magnitude  = MAG_W'(root_floor_sat(gx * gx + gy * gy));
            g.centre_row = ROW_W'(r - 1);
            g.centre_col = COL_W'(col_pos - 1);
            g.frame_done = (r == h - 1) && (col_pos == w - 1);
            expected_gradients.push_back(g);
         end

         // line buffers and window shift
         line_two_above[c]    = mid;
         two_above_written[c] = mid_known;
         line_above[c]        = p;
         above_written[c]     = 1'b1;
         window[0]            = window[3];
         window[1]            = window[4];
         window[2]            = window[5];
         window[3]            = top;
         window[4]            = mid;
         window[5]            = p;
         window_written[0]    = window_written[3];
         window_written[1]    = window_written[4];
         window_written[2]    = window_written[5];
         window_written[3]    = top_known;
         window_written[4]    = mid_known;
         window_written[5]    = 1'b1;

         // raster position of the next pixel
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 12'hFFF);
         end else begin
            col_pos = (col_pos + 1) & 10'h3FF;
         end
      endfunction

      function int unsigned outstanding();
         return expected_gradients.size();
      endfunction

      function void check_result(gradient_type got);
         gradient_type want;
         if (expected_gradients.size() == 0) begin
            $error("unexpected gradient result at row %0d col %0d",
                   got.centre_row, got.centre_col);
            errors++;
            return;
         end
         want = expected_gradients.pop_front();
         gradients_checked++;
         if (want.frame_done) frames_closed++;
         if (got.magnitude !== want.magnitude) begin
            $error("magnitude: expected %0d, actual %0d", want.magnitude, got.magnitude);
            errors++;
         end
         if (got.centre_row !== want.centre_row) begin
            $error("centre_row: expected %0d, actual %0d", want.centre_row, got.centre_row);
            errors++;
         end
         if (got.centre_col !== want.centre_col) begin
            $error("centre_col: expected %0d, actual %0d", want.centre_col, got.centre_col);
            errors++;
         end
         if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, actual %0d", want.frame_done, got.frame_done);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   sink_ready = 1'b0;
   sink_mode_type          sink_mode = READY_ALWAYS;
   logic [2:0]             sink_phase = '0;
   int unsigned            sink_hold = 0;
   int unsigned            idle_cycles = 0;
   int unsigned            burst_left = 0;
   int unsigned            random_pixels = 0;
   int unsigned            size_settings = 0;

   gradient_scoreboard board = new();

   pgm_req_if req_ch ();
   pgm_rsp_if rsp_ch ();

   prewitt_gradient_magnitude dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_ch),
      .rsp_if       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   assign rsp_ch.ready = sink_ready;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result sink: switches between stall patterns every so often
   always @(posedge clock) begin
      if (sink_hold == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_hold <= $urandom_range(16, 160);
      end else begin
         sink_hold <= sink_hold - 1;
      end
      sink_phase <= sink_phase + 1'b1;
      case (sink_mode)
         READY_ALWAYS: sink_ready <= 1'b1;
         READY_COIN:   sink_ready <= 1'($urandom_range(0, 1));
         READY_MOSTLY: sink_ready <= ($urandom_range(0, 5) != 0);
         default:      sink_ready <= (sink_phase < 3'd5);
      endcase
   end

   // result check and watchdog on transaction activity
   always @(posedge clock) begin
      if (reset !== 1'b0) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(gradient_type'{rsp_ch.magnitude, rsp_ch.centre_row,
                                              rsp_ch.centre_col, rsp_ch.frame_done});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             csr_write_en) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // one pixel transaction, then maybe a gap before the next burst
   task automatic send_pixel(input logic [PIXEL_W-1:0] value, input bit start);
      bit          start_frame;
      int unsigned gap;
      start_frame = start || board.reads_unwritten(start);
      req_ch.valid       <= 1'b1;
      req_ch.pixel       <= value;
      req_ch.frame_start <= start_frame;
      do @(posedge clock); while (!req_ch.ready);
      board.note_pixel(value, start_frame);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // stop sending, wait for every result and for border pixels still in flight
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] width,
                            input logic [CSR_DATA_W-1:0] height);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_IMAGE_WIDTH;
      csr_wdata    <= width;
      @(posedge clock);
      board.write_register(CSR_IMAGE_WIDTH, width);
      csr_index    <= CSR_IMAGE_HEIGHT;
      csr_wdata    <= height;
      @(posedge clock);
      board.write_register(CSR_IMAGE_HEIGHT, height);
      csr_write_en <= 1'b0;
      size_settings++;
   endtask

   // random frames: mostly clean raster sequences, a few early restarts
   task automatic run_frames(input int unsigned count);
      int unsigned        hold_at;
      bit                 start;
      logic [PIXEL_W-1:0] value;
      hold_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, count - 1) : count;
      for (int unsigned i = 0; i < count; i++) begin
         // the first pixel sometimes carries the old counters over
         if (i == 0) start = ($urandom_range(0, 4) != 0);
         else start = ($urandom_range(0, 63) == 0);
         case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = '1;
            default: value = PIXEL_W'($urandom_range(0, 255));
         endcase
         // sender holds off mid-frame until the sink has caught up
         if (i == hold_at) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (board.outstanding() != 0);
         end
         send_pixel(value, start);
         random_pixels++;
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] width_pick;
      logic [CSR_DATA_W-1:0] height_pick;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.pixel       <= '0;
      req_ch.frame_start <= 1'b0;
      csr_write_en       <= 1'b0;
      csr_index          <= CSR_IMAGE_WIDTH;
      csr_wdata          <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset frame size: two full rows and the start of a third
      for (int i = 0; i < 2 * int'(IMAGE_WIDTH_RESET) + 8; i++)
         send_pixel(PIXEL_W'($urandom_range(0, 255)), i == 0);
      drain();

      // smallest frame: full-scale vertical edge, saturates
      configure(13'd3, 13'd3);
      for (int i = 0; i < 9; i++)
         send_pixel((i % 3 == 2) ? 8'd255 : 8'd0, i == 0);
      // next frame follows by wrap alone; one bright corner
      for (int i = 0; i < 9; i++)
         send_pixel((i == 8) ? 8'd60 : 8'd0, 1'b0);
      // restart part-way through the second row
      repeat (4) send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b1);
      drain();

      // random sizes, small ones mostly, plus clamped values below the minimum
      while (random_pixels < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       width_pick = CSR_DATA_W'($urandom_range(0, 2));
            1:       width_pick = CSR_DATA_W'(MIN_DIM);
            9:       width_pick = CSR_DATA_W'($urandom_range(17, 64));
            default: width_pick = CSR_DATA_W'($urandom_range(4, 16));
         endcase
         case ($urandom_range(0, 7))
            0:       height_pick = CSR_DATA_W'($urandom_range(0, 2));
            1:       height_pick = CSR_DATA_W'(MIN_DIM);
            default: height_pick = CSR_DATA_W'($urandom_range(4, 9));
         endcase
         configure(width_pick, height_pick);
         run_frames($urandom_range(24, 96));
         drain();
      end

      $display("summary: %0d pixels sent, %0d gradients checked, %0d frame ends",
               board.pixels_seen, board.gradients_checked, board.frames_closed);
      $display("summary: %0d frame sizes, the reset size, 3x3 and clamped small frames",
               size_settings);
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
